// ===== rtl/core/point_to_map_sheet_index_core_defines.svh =====
// assertion macros for the map sheet index core
// used by point_to_map_sheet_index_core.sv, expects clk and rst_n in scope
`ifndef POINT_TO_MAP_SHEET_INDEX_CORE_DEFINES_SVH
`define POINT_TO_MAP_SHEET_INDEX_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define PTMSI_ASSERT_IMP(label, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define PTMSI_ASSERT_NXT(label, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define PTMSI_ASSERT_IMP(label, a, c)
`define PTMSI_ASSERT_NXT(label, a, c)
`endif
`endif

// ===== rtl/core/ptmsi_pkg.sv =====
// types and constants of the map sheet index core
// no dependencies
package ptmsi_pkg;

  typedef struct packed {
    logic signed [20:0] lon_arcsec;
    logic signed [19:0] lat_arcsec;
    logic [2:0]         scale;
    logic               single_sheet;
  } ptmsi_in_t;

  typedef struct packed {
    logic       bad_coord;
    logic       south;
    logic [4:0] band_letter;
    logic [5:0] zone;
    logic [7:0] sub_sheet;
    logic [2:0] quarter;
    logic [2:0] zone_span;
    logic [2:0] sub_span;
    logic [1:0] quarter_span;
  } ptmsi_out_t;

  localparam logic [2:0] SC_1M   = 3'd0;
  localparam logic [2:0] SC_500K = 3'd1;
  localparam logic [2:0] SC_200K = 3'd2;
  localparam logic [2:0] SC_100K = 3'd3;
  localparam logic [2:0] SC_50K  = 3'd4;

  localparam logic signed [20:0] LON_LIMIT = 21'sd648000;
  localparam logic signed [19:0] LAT_LIMIT = 20'sd324000;
  localparam logic [20:0] LON_BIAS = 21'd648000;
  localparam logic [19:0] LAT_BIAS = 20'd331200;

  localparam logic [20:0] LON_CELL = 21'd21600;
  localparam logic [19:0] LAT_CELL = 20'd14400;
  localparam logic [18:0] BAND_CELL = 19'd14400;

  localparam logic [33:0] RCP_LON_CELL = 34'd6213;
  localparam logic [33:0] RCP_LAT_CELL = 34'd9320;
  localparam logic [31:0] RCP_BAND_CELL = 32'd9320;
  localparam logic [28:0] RCP_LAT_Q24 = 29'd27963;
  localparam logic [28:0] RCP_LON_Q24 = 29'd18642;

  localparam logic [4:0] BAND_PAIR_LO = 5'd15;
  localparam logic [4:0] BAND_PAIR_HI = 5'd18;
  localparam logic [4:0] BAND_QUAD_LO = 5'd19;
  localparam logic [4:0] BAND_QUAD_HI = 5'd20;

  function automatic logic [7:0] pair_start(input logic [7:0] v);
    return ((v - 8'd1) & 8'hFE) + 8'd1;
  endfunction

  function automatic logic [7:0] quad_start(input logic [7:0] v);
    return ((v - 8'd1) & 8'hFC) + 8'd1;
  endfunction

endpackage

// ===== rtl/core/point_to_map_sheet_index_core.sv =====
// map sheet index of a point, four register stages
// an accepted item moves through the stage 1, 2 and 3 registers and then the output register
// throughput: one item per cycle while out_stall is low, set by the per-stage handshake of the pipeline
// the reciprocal multipliers of the first and third stages set the stage depth
// rst_n synchronous active low: clears all stage valid bits, payload is not reset
// depends on ptmsi_pkg and point_to_map_sheet_index_core_defines.svh
`include "point_to_map_sheet_index_core_defines.svh"
module point_to_map_sheet_index_core (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  ptmsi_pkg::ptmsi_in_t   in_item,
  output logic                   out_valid,
  input  logic                   out_stall,
  output ptmsi_pkg::ptmsi_out_t  out_item
);
  import ptmsi_pkg::*;

  logic rdy1, rdy2, rdy3, rdy4;

  logic        s1_v_r, s1_bad_r, s1_south_r, s1_single_r;
  logic [2:0]  s1_scale_r;
  logic [20:0] s1_lon_b_r;
  logic [19:0] s1_lat_b_r;
  logic [18:0] s1_alat_r;
  logic [33:0] s1_plon_r, s1_plat_r;
  logic [31:0] s1_palat_r;

  logic        s1_bad_nxt;
  logic [20:0] s1_lon_b_nxt;
  logic [19:0] s1_lat_b_nxt;
  logic [19:0] alat_full;
  logic [18:0] s1_alat_nxt;

  logic        s2_v_r, s2_bad_r, s2_south_r, s2_single_r;
  logic [2:0]  s2_scale_r;
  logic [5:0]  s2_zone_r;
  logic [4:0]  s2_band_r;
  logic [14:0] s2_rlon_r;
  logic [13:0] s2_rlat_r;

  logic [5:0]  ql0, qt0;
  logic [4:0]  qa0;
  logic [20:0] rem_lon0, rem_lon1;
  logic [19:0] rem_lat0, rem_lat1;
  logic [18:0] rem_a0;
  logic        lon_hi, lat_hi, band_hi;
  logic [5:0]  s2_zone_nxt;
  logic [4:0]  s2_band_nxt;

  logic        s3_v_r, s3_bad_r, s3_south_r, s3_single_r;
  logic [2:0]  s3_scale_r;
  logic [5:0]  s3_zone_r;
  logic [4:0]  s3_band_r;
  logic [28:0] s3_plat_r, s3_plon_r;

  logic       out_valid_r;
  ptmsi_out_t out_item_r, out_item_nxt;

  assign rdy4 = !out_valid_r || !out_stall;
  assign rdy3 = !s3_v_r || rdy4;
  assign rdy2 = !s2_v_r || rdy3;
  assign rdy1 = !s1_v_r || rdy2;
  assign in_stall  = !rdy1;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // stage 1: range check, bias, reciprocal products
  always_comb begin
    s1_bad_nxt = (in_item.lon_arcsec < -LON_LIMIT) || (in_item.lon_arcsec > LON_LIMIT) ||
                 (in_item.lat_arcsec < -LAT_LIMIT) || (in_item.lat_arcsec > LAT_LIMIT) ||
                 (in_item.scale > SC_50K);
    s1_lon_b_nxt = $unsigned(in_item.lon_arcsec) + LON_BIAS;
    s1_lat_b_nxt = $unsigned(in_item.lat_arcsec) + LAT_BIAS;
    alat_full = in_item.lat_arcsec[19] ? $unsigned(-in_item.lat_arcsec)
                                       : $unsigned(in_item.lat_arcsec);
    s1_alat_nxt = alat_full[18:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (rdy1) begin
      s1_v_r <= in_valid;
    end
    if (rdy1 && in_valid) begin
      s1_bad_r    <= s1_bad_nxt;
      s1_south_r  <= in_item.lat_arcsec[19];
      s1_single_r <= in_item.single_sheet;
      s1_scale_r  <= in_item.scale;
      s1_lon_b_r  <= s1_lon_b_nxt;
      s1_lat_b_r  <= s1_lat_b_nxt;
      s1_alat_r   <= s1_alat_nxt;
      s1_plon_r   <= {13'd0, s1_lon_b_nxt} * RCP_LON_CELL;
      s1_plat_r   <= {14'd0, s1_lat_b_nxt} * RCP_LAT_CELL;
      s1_palat_r  <= {13'd0, s1_alat_nxt} * RCP_BAND_CELL;
    end
  end

  // stage 2: quotient correction, cell remainders
  always_comb begin
    ql0 = s1_plon_r[32:27];
    qt0 = s1_plat_r[32:27];
    qa0 = s1_palat_r[31:27];
    rem_lon0 = s1_lon_b_r - ({15'd0, ql0} * LON_CELL);
    rem_lat0 = s1_lat_b_r - ({14'd0, qt0} * LAT_CELL);
    rem_a0   = s1_alat_r - ({14'd0, qa0} * BAND_CELL);
    lon_hi  = rem_lon0 >= LON_CELL;
    lat_hi  = rem_lat0 >= LAT_CELL;
    band_hi = rem_a0 >= BAND_CELL;
    rem_lon1 = lon_hi ? (rem_lon0 - LON_CELL) : rem_lon0;
    rem_lat1 = lat_hi ? (rem_lat0 - LAT_CELL) : rem_lat0;
    s2_zone_nxt = ql0 + {5'd0, lon_hi} + 6'd1;
    s2_band_nxt = qa0 + {4'd0, band_hi};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (rdy2) begin
      s2_v_r <= s1_v_r;
    end
    if (rdy2 && s1_v_r) begin
      s2_bad_r    <= s1_bad_r;
      s2_south_r  <= s1_south_r;
      s2_single_r <= s1_single_r;
      s2_scale_r  <= s1_scale_r;
      s2_zone_r   <= s2_zone_nxt;
      s2_band_r   <= s2_band_nxt;
      s2_rlon_r   <= rem_lon1[14:0];
      s2_rlat_r   <= rem_lat1[13:0];
    end
  end

  // stage 3: position in 1/24 steps of the cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (rdy3) begin
      s3_v_r <= s2_v_r;
    end
    if (rdy3 && s2_v_r) begin
      s3_bad_r    <= s2_bad_r;
      s3_south_r  <= s2_south_r;
      s3_single_r <= s2_single_r;
      s3_scale_r  <= s2_scale_r;
      s3_zone_r   <= s2_zone_r;
      s3_band_r   <= s2_band_r;
      s3_plat_r   <= {15'd0, s2_rlat_r} * RCP_LAT_Q24;
      s3_plon_r   <= {14'd0, s2_rlon_r} * RCP_LON_Q24;
    end
  end

  // stage 4: sheet numbers and grouping
  always_comb begin
    logic [4:0] k24, c24;
    logic [3:0] k12, c12, n, rowi, coli, row;
    logic [7:0] sub, quarter, zone;
    logic [2:0] zspan, sspan;
    logic [1:0] qspan;
    logic       pair, quad;

    k24 = s3_plat_r[28:24];
    c24 = s3_plon_r[28:24];
    k12 = k24[4:1];
    c12 = c24[4:1];
    case (s3_scale_r)
      SC_1M: begin
        n = 4'd1; rowi = 4'd0; coli = 4'd0;
      end
      SC_500K: begin
        n = 4'd2;
        rowi = {3'd0, k12 >= 4'd6};
        coli = {3'd0, c12 >= 4'd6};
      end
      SC_200K: begin
        n = 4'd6;
        rowi = {1'b0, k12[3:1]};
        coli = {1'b0, c12[3:1]};
      end
      default: begin
        n = 4'd12; rowi = k12; coli = c12;
      end
    endcase
    row = n - 4'd1 - rowi;
    sub = ({4'd0, row} * {4'd0, n}) + {4'd0, coli} + 8'd1;
    quarter = {6'd0, ~k24[0], c24[0]} + 8'd1;
    zone = {2'd0, s3_zone_r};
    pair = !s3_single_r && (s3_band_r >= BAND_PAIR_LO) && (s3_band_r <= BAND_PAIR_HI);
    quad = !s3_single_r && (s3_band_r >= BAND_QUAD_LO) && (s3_band_r <= BAND_QUAD_HI);
    zspan = 3'd1;
    sspan = 3'd1;
    qspan = 2'd1;

    case (s3_scale_r)
      SC_1M: begin
        if (pair) begin
          zone = pair_start(zone); zspan = 3'd2;
        end
        if (quad) begin
          zone = quad_start(zone); zspan = 3'd4;
        end
        sub = 8'd0;
        sspan = 3'd0;
      end
      SC_500K: begin
        if (pair) begin
          sub = pair_start(sub); sspan = 3'd2;
        end
        if (quad) begin
          zone = pair_start(zone); zspan = 3'd2;
          sub = pair_start(sub); sspan = 3'd2;
        end
      end
      SC_200K, SC_100K: begin
        if (pair) begin
          sub = pair_start(sub); sspan = 3'd2;
        end
        if (quad) begin
          sub = quad_start(sub); sspan = 3'd4;
        end
      end
      default: begin
        if (pair) begin
          quarter = pair_start(quarter); qspan = 2'd2;
        end
        if (quad) begin
          sub = pair_start(sub); sspan = 3'd2;
          quarter = pair_start(quarter); qspan = 2'd2;
        end
      end
    endcase
    if (s3_scale_r != SC_50K) begin
      quarter = 8'd0;
      qspan = 2'd0;
    end

    out_item_nxt = '0;
    if (s3_bad_r) begin
      out_item_nxt.bad_coord = 1'b1;
    end else begin
      out_item_nxt.south        = s3_south_r;
      out_item_nxt.band_letter  = s3_band_r;
      out_item_nxt.zone         = zone[5:0];
      out_item_nxt.sub_sheet    = sub;
      out_item_nxt.quarter      = quarter[2:0];
      out_item_nxt.zone_span    = zspan;
      out_item_nxt.sub_span     = sspan;
      out_item_nxt.quarter_span = qspan;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rdy4) begin
      out_valid_r <= s3_v_r;
    end
    if (rdy4 && s3_v_r) begin
      out_item_r <= out_item_nxt;
    end
  end

  `PTMSI_ASSERT_IMP(a_bad_zero, out_valid_r && out_item_r.bad_coord, out_item_r.zone == 6'd0 && out_item_r.sub_sheet == 8'd0 && out_item_r.band_letter == 5'd0 && out_item_r.zone_span == 3'd0)
  `PTMSI_ASSERT_IMP(a_good_zone, out_valid_r && !out_item_r.bad_coord, out_item_r.zone != 6'd0 && out_item_r.zone_span != 3'd0 && out_item_r.band_letter <= 5'd22)
  `PTMSI_ASSERT_IMP(a_quarter_pair, out_valid_r, (out_item_r.quarter_span == 2'd0) == (out_item_r.quarter == 3'd0))
  `PTMSI_ASSERT_NXT(a_s1_hold, s1_v_r && !rdy2, s1_v_r)

endmodule
